@@ design/dmx_pkg.sv @@
// ----------------------------------------------------------------------------
// dmx_pkg
// Types and constants shared by the DMX512 frame transmitter modules.
// ----------------------------------------------------------------------------
package dmx_pkg;

  // Widest slot index: slots 0 .. 512 (start code plus 512 channels).
  localparam int SLOT_W = 10;
  localparam int CHAN_W = 10;
  localparam int BIT_W = 4;
  localparam int CFG_W = 16;
  localparam int BITS_PER_SLOT = 11;

  // Operation codes of an input word.
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_BREAK = 2'd0;
  localparam logic [1:0] CFG_MAB   = 2'd1;
  localparam logic [1:0] CFG_MBB   = 2'd2;
  localparam logic [1:0] CFG_BIT   = 2'd3;

  // Register reset values.
  localparam logic [15:0] BREAK_RST = 16'd176;
  localparam logic [15:0] MAB_RST   = 16'd12;
  localparam logic [15:0] MBB_RST   = 16'd20;
  localparam logic [7:0]  BIT_RST   = 8'd4;

  typedef enum logic [1:0] {
    PH_BREAK = 2'd0,
    PH_MAB   = 2'd1,
    PH_DATA  = 2'd2,
    PH_MBB   = 2'd3
  } phase_t;

  typedef struct packed {
    logic [1:0]        operation;
    logic [CHAN_W-1:0] channel;
    logic [7:0]        level;
  } dmx_in_t;

  typedef struct packed {
    logic       tx_level;
    logic [1:0] phase;
    logic [7:0] read_value;
    logic       accepted;
  } dmx_out_t;

  // Visible frame position after a step.
  typedef struct packed {
    phase_t            phase;
    logic [SLOT_W-1:0] slot;
    logic [BIT_W-1:0]  bit_idx;
  } frame_state_t;

  // Side information that travels with a word while its memory reads complete.
  typedef struct packed {
    phase_t           phase;
    logic [BIT_W-1:0] bit_idx;
    logic             slot_zero;
    logic             fwd_hit;
    logic [7:0]       fwd_level;
    logic             rd_sel;
    logic             ok;
  } s2_meta_t;

endpackage

@@ design/dmx_timing.sv @@
// ----------------------------------------------------------------------------
// dmx_timing
// Configuration registers and the break / mark / slot / bit counters.
// ----------------------------------------------------------------------------
module dmx_timing import dmx_pkg::*; #(
  parameter int NUM_CHANNELS = 512
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  logic             tick_en,
  output frame_state_t     st_post
);

  logic [15:0] break_ticks_r;
  logic [15:0] mab_ticks_r;
  logic [15:0] mbb_ticks_r;
  logic [7:0]  bit_ticks_r;

  frame_state_t st_r;
  logic [15:0]  pc_r, pc_nxt;
  logic [7:0]   bc_r, bc_nxt;

  logic [15:0]       pc_inc;
  logic [7:0]        bc_inc;
  logic [7:0]        bit_len;
  logic [15:0]       len_sel;
  logic [15:0]       len1;
  logic [BIT_W-1:0]  bit_inc;
  logic [SLOT_W:0]   slot_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      break_ticks_r <= BREAK_RST;
      mab_ticks_r   <= MAB_RST;
      mbb_ticks_r   <= MBB_RST;
      bit_ticks_r   <= BIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BREAK: break_ticks_r <= cfg_wdata;
        CFG_MAB:   mab_ticks_r   <= cfg_wdata;
        CFG_MBB:   mbb_ticks_r   <= cfg_wdata;
        CFG_BIT:   bit_ticks_r   <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    pc_inc   = pc_r + 16'd1;
    bc_inc   = bc_r + 8'd1;
    bit_len  = (bit_ticks_r == 8'd0) ? 8'd1 : bit_ticks_r;
    bit_inc  = st_r.bit_idx + BIT_W'(1);
    slot_inc = {1'b0, st_r.slot} + (SLOT_W+1)'(1);
    case (st_r.phase)
      PH_BREAK: len_sel = break_ticks_r;
      PH_MAB:   len_sel = mab_ticks_r;
      default:  len_sel = mbb_ticks_r;
    endcase
    len1 = (len_sel == 16'd0) ? 16'd1 : len_sel;

    st_post = st_r;
    pc_nxt  = pc_r;
    bc_nxt  = bc_r;
    if (tick_en) begin
      if (st_r.phase == PH_DATA) begin
        bc_nxt = bc_inc;
        if (bc_inc >= bit_len) begin
          bc_nxt = 8'd0;
          if (bit_inc >= BIT_W'(BITS_PER_SLOT)) begin
            st_post.bit_idx = '0;
            if (slot_inc > (SLOT_W+1)'(NUM_CHANNELS)) begin
              st_post.slot  = '0;
              st_post.phase = PH_MBB;
              pc_nxt        = 16'd0;
            end else begin
              st_post.slot = slot_inc[SLOT_W-1:0];
            end
          end else begin
            st_post.bit_idx = bit_inc;
          end
        end
      end else begin
        pc_nxt = pc_inc;
        // A counter that wraps past its top also ends the phase.
        if (pc_inc >= len1 || pc_inc == 16'd0) begin
          pc_nxt = 16'd0;
          unique case (st_r.phase)
            PH_BREAK: st_post.phase = PH_MAB;
            PH_MAB: begin
              st_post.phase   = PH_DATA;
              st_post.slot    = '0;
              st_post.bit_idx = '0;
              bc_nxt          = 8'd0;
            end
            default: st_post.phase = PH_BREAK;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '{phase: PH_BREAK, slot: '0, bit_idx: '0};
      pc_r <= 16'd0;
      bc_r <= 8'd0;
    end else begin
      st_r <= st_post;
      pc_r <= pc_nxt;
      bc_r <= bc_nxt;
    end
  end

  // Outside the data phase the slot position is always parked at zero.
  a_parked: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.phase != PH_DATA |-> (st_r.slot == '0 && st_r.bit_idx == '0))
    else $error("slot position not parked outside data phase");

endmodule

@@ design/dmx_chan_mem.sv @@
// ----------------------------------------------------------------------------
// dmx_chan_mem
// Channel byte store: one write port, two registered read ports, and a
// clearing sweep after reset.
// ----------------------------------------------------------------------------
module dmx_chan_mem import dmx_pkg::*; #(
  parameter int NUM_CHANNELS = 512,
  parameter int AW = 9
) (
  input  logic          clk,
  input  logic          rst_n,
  output logic          busy,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output logic [7:0]    rdata_a,
  output logic [7:0]    rdata_b
);

  logic [7:0]    mem [NUM_CHANNELS];
  logic          clr_r;
  logic [AW-1:0] clr_addr_r;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_r) begin
      if (clr_addr_r == AW'(NUM_CHANNELS - 1)) begin
        clr_r <= 1'b0;
      end else begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
    end
  end

  assign busy      = clr_r;
  assign mem_we    = clr_r | we;
  assign mem_waddr = clr_r ? clr_addr_r : waddr;
  assign mem_wdata = clr_r ? 8'd0 : wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

@@ design/dmx512_frame_transmitter.sv @@
// ----------------------------------------------------------------------------
// dmx512_frame_transmitter
// Repeating DMX512 transmitter with a channel store and a word-driven clock.
// ----------------------------------------------------------------------------
// Each input word is one tick, one channel write or one channel read, and each
// word gives exactly one result word. The block takes one word per clock cycle
// unless the store is clearing or back-pressure holds it. Each result passes
// through the registered read of the channel store and then the output
// register. After reset the store is swept to zero, during which in_ready
// stays low; configuration writes are taken at any time.
module dmx512_frame_transmitter import dmx_pkg::*; #(
  parameter int NUM_CHANNELS = 512
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  dmx_in_t          in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output dmx_out_t         out_data,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  logic         accept;
  logic         mem_busy;
  logic         is_tick, is_write, is_read, in_range, ok;
  frame_state_t st_post;
  logic [SLOT_W-1:0] slot_m1;
  logic [AW-1:0] chan_addr, slot_addr;
  logic [7:0]   rdata_a, rdata_b;

  logic         s2_valid_r, s2_valid_nxt, s2_adv;
  s2_meta_t     s2_meta_r, s2_meta_nxt;
  logic         out_valid_r, out_valid_nxt;
  dmx_out_t     out_data_r, out_data_nxt;
  logic [7:0]   line_byte;
  logic         line_bit;

  assign is_tick  = in_data.operation == OP_TICK;
  assign is_write = in_data.operation == OP_WRITE;
  assign is_read  = in_data.operation == OP_READ;
  assign in_range = in_data.channel < CHAN_W'(NUM_CHANNELS);
  assign ok       = (is_write | is_read) & in_range;

  assign s2_adv   = ~out_valid_r | out_ready;
  assign in_ready = ~mem_busy & (~s2_valid_r | s2_adv);
  assign accept   = in_valid & in_ready;

  dmx_timing #(.NUM_CHANNELS(NUM_CHANNELS)) u_timing (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .tick_en   (accept & is_tick),
    .st_post   (st_post)
  );

  // Slot k carries channel k-1; slot zero is the start code and reads nothing.
  assign slot_m1   = st_post.slot - SLOT_W'(1);
  assign slot_addr = (st_post.slot == '0) ? '0 : slot_m1[AW-1:0];
  assign chan_addr = in_range ? in_data.channel[AW-1:0] : '0;

  dmx_chan_mem #(.NUM_CHANNELS(NUM_CHANNELS), .AW(AW)) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .busy    (mem_busy),
    .we      (accept & is_write & in_range),
    .waddr   (chan_addr),
    .wdata   (in_data.level),
    .re      (accept),
    .raddr_a (chan_addr),
    .raddr_b (slot_addr),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  // A write to the channel now on the line lands in the same cycle as the
  // slot read, so its byte is forwarded past the memory.
  always_comb begin
    s2_meta_nxt.phase     = st_post.phase;
    s2_meta_nxt.bit_idx   = st_post.bit_idx;
    s2_meta_nxt.slot_zero = st_post.slot == '0;
    s2_meta_nxt.fwd_hit   = is_write & in_range & (st_post.slot != '0) &
                            (in_data.channel == slot_m1);
    s2_meta_nxt.fwd_level = in_data.level;
    s2_meta_nxt.rd_sel    = is_read & in_range;
    s2_meta_nxt.ok        = ok;
  end

  assign s2_valid_nxt = accept | (s2_valid_r & ~s2_adv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s2_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s2_meta_r <= s2_meta_nxt;
    end
  end

  always_comb begin
    if (s2_meta_r.fwd_hit) begin
      line_byte = s2_meta_r.fwd_level;
    end else if (s2_meta_r.slot_zero) begin
      line_byte = 8'd0;
    end else begin
      line_byte = rdata_b;
    end
    case (s2_meta_r.phase)
      PH_BREAK: line_bit = 1'b0;
      PH_DATA: begin
        if (s2_meta_r.bit_idx == '0) begin
          line_bit = 1'b0;
        end else if (s2_meta_r.bit_idx <= BIT_W'(8)) begin
          line_bit = line_byte[3'(s2_meta_r.bit_idx - BIT_W'(1))];
        end else begin
          line_bit = 1'b1;
        end
      end
      default: line_bit = 1'b1;
    endcase
    out_data_nxt.tx_level   = line_bit;
    out_data_nxt.phase      = s2_meta_r.phase;
    out_data_nxt.read_value = s2_meta_r.rd_sel ? rdata_a : 8'd0;
    out_data_nxt.accepted   = s2_meta_r.ok;
  end

  assign out_valid_nxt = (s2_valid_r & s2_adv) | (out_valid_r & ~out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid_r && s2_adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    mem_busy |-> !in_ready)
    else $error("word accepted during store clearing");

  a_accept_fills_s2: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> s2_valid_r)
    else $error("accepted word lost before read stage");

  a_s2_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && !s2_adv) |=> (s2_valid_r && $stable(rdata_a) && $stable(rdata_b)))
    else $error("stalled read stage lost its memory data");

  a_rejected_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && !s2_meta_r.ok) |-> out_data_nxt.read_value == 8'd0)
    else $error("read value not zero on rejected word");

endmodule

@@ tb/sv/dmx512_frame_transmitter_tb.sv @@
// ----------------------------------------------------------------------------
// dmx512_frame_transmitter_tb
// Self-checking bench for the repeating DMX512 frame transmitter.
// ----------------------------------------------------------------------------
// A queue of words (ticks, channel writes, channel reads and the unused code)
// feeds a valid/ready driver with random gaps. Each accepted word is run
// through a cycle-free model of the frame sequencer and channel store, and the
// expected result is queued. A monitor with random back-pressure checks every
// result in order. The run steps through several timing settings, from the
// reset values through all-one, all-zero and all-maximum lengths to random
// ones. The block is built with its full channel count, so the short lengths
// are what carry the line from break through mark and into the data slots.
// ----------------------------------------------------------------------------
module dmx512_frame_transmitter_tb import dmx_pkg::*; ;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_CH = 512;
  localparam int CH_AW = $clog2(N_CH);
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int LONG_HOLD_AT = 150;
  localparam int LONG_HOLD = 200;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  dmx_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  dmx_out_t out_data;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_BREAK;
  logic [CFG_W-1:0] cfg_wdata = '0;

  dmx512_frame_transmitter #(.NUM_CHANNELS(N_CH)) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // Transmitter model: timing registers, frame position and channel store.
  logic [15:0] len_break = BREAK_RST;
  logic [15:0] len_mab = MAB_RST;
  logic [15:0] len_mbb = MBB_RST;
  logic [7:0] len_bit = BIT_RST;
  phase_t tx_phase = PH_BREAK;
  logic [15:0] phase_ticks = '0;
  logic [9:0] slot_pos = '0;
  logic [3:0] bit_pos = '0;
  logic [7:0] bit_ticks_spent = '0;
  logic [7:0] chan_mem [N_CH] = '{default: 8'd0};

  dmx_in_t words_to_send[$];
  dmx_out_t pending_results[$];
  dmx_out_t want;

  int gap_left = 0;
  int tx_burst = 0;
  int rx_burst = 0;
  int rx_hold = 0;
  int rx_stall_left = 0;
  int fault_count = 0;
  int results_checked = 0;
  int n_tick = 0;
  int n_write = 0;
  int n_read = 0;
  int n_unused = 0;
  int frames_done = 0;
  int settings_used = 1;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("dmx512_frame_transmitter_tb: errors");
    $finish;
  end

  // Zero or random idle cycles, with occasional stretches of no idling at all.
  function automatic int draw_gap(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      burst = $urandom_range(16, 48);
      return 0;
    end
    return $urandom_range(0, 8);
  endfunction

  // Applies one word to the model and returns the result it must produce.
  function automatic dmx_out_t step_transmitter(dmx_in_t w);
    dmx_out_t r;
    logic [15:0] len;
    logic [7:0] eff_bit;
    logic [7:0] slot_val;
    logic [9:0] slot_prev;
    r = '0;
    case (w.operation)
      OP_TICK: begin
        if (tx_phase == PH_DATA) begin
          eff_bit = (len_bit == 8'd0) ? 8'd1 : len_bit;
          bit_ticks_spent = bit_ticks_spent + 8'd1;
          if (bit_ticks_spent >= eff_bit) begin
            bit_ticks_spent = '0;
            bit_pos = bit_pos + 4'd1;
            if (bit_pos >= BITS_PER_SLOT) begin
              bit_pos = '0;
              slot_pos = slot_pos + 10'd1;
              if (slot_pos > N_CH) begin
                slot_pos = '0;
                phase_ticks = '0;
                tx_phase = PH_MBB;
              end
            end
          end
        end else begin
          len = (tx_phase == PH_BREAK) ? len_break :
                (tx_phase == PH_MAB) ? len_mab : len_mbb;
          if (len == 16'd0) len = 16'd1;
          phase_ticks = phase_ticks + 16'd1;
          if (phase_ticks >= len || phase_ticks == 16'd0) begin
            phase_ticks = '0;
            case (tx_phase)
              PH_BREAK: tx_phase = PH_MAB;
              PH_MAB: begin
                tx_phase = PH_DATA;
                slot_pos = '0;
                bit_pos = '0;
                bit_ticks_spent = '0;
              end
              default: begin
                tx_phase = PH_BREAK;
                frames_done++;
              end
            endcase
          end
        end
      end
      OP_WRITE: begin
        if (w.channel < N_CH) begin
          chan_mem[w.channel[CH_AW-1:0]] = w.level;
          r.accepted = 1'b1;
        end
      end
      OP_READ: begin
        if (w.channel < N_CH) begin
          r.read_value = chan_mem[w.channel[CH_AW-1:0]];
          r.accepted = 1'b1;
        end
      end
      default: ;
    endcase

    // Line level follows the position after the step; slot 0 is the start code.
    case (tx_phase)
      PH_BREAK: r.tx_level = 1'b0;
      PH_DATA: begin
        slot_prev = slot_pos - 10'd1;
        slot_val = (slot_pos == 10'd0) ? 8'd0 : chan_mem[slot_prev[CH_AW-1:0]];
        if (bit_pos == 4'd0) r.tx_level = 1'b0;
        else if (bit_pos <= 4'd8) r.tx_level = slot_val[3'(bit_pos - 4'd1)];
        else r.tx_level = 1'b1;
      end
      default: r.tx_level = 1'b1;
    endcase
    r.phase = tx_phase;
    return r;
  endfunction

  // Sender: offers queued words and holds each one until it is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && in_ready) begin
        pending_results.push_back(step_transmitter(in_data));
        case (in_data.operation)
          OP_TICK: n_tick++;
          OP_WRITE: n_write++;
          OP_READ: n_read++;
          default: n_unused++;
        endcase
      end
      if (in_valid && !in_ready) begin
        // Word not taken yet: keep it on the bus.
      end else if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (words_to_send.size() > 0) begin
        in_valid <= 1'b1;
        in_data <= words_to_send.pop_front();
        gap_left <= draw_gap(tx_burst);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: checks each result against the oldest expectation.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_stall_left <= 0;
    end else if (out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result level=%0d phase=%0d read=%0h acc=%0d",
                 $time, out_data.tx_level, out_data.phase, out_data.read_value,
                 out_data.accepted);
        fault_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.tx_level !== want.tx_level || out_data.phase !== want.phase ||
            out_data.read_value !== want.read_value ||
            out_data.accepted !== want.accepted) begin
          $display("%0t: result %0d expected level=%0d phase=%0d read=%0h acc=%0d",
                   $time, results_checked, want.tx_level, want.phase,
                   want.read_value, want.accepted);
          $display("%0t: result %0d actual   level=%0d phase=%0d read=%0h acc=%0d",
                   $time, results_checked, out_data.tx_level, out_data.phase,
                   out_data.read_value, out_data.accepted);
          fault_count++;
        end
      end
      results_checked++;
      // One long hold-off lets the sender back up into the block.
      rx_hold = (results_checked == LONG_HOLD_AT) ? LONG_HOLD : draw_gap(rx_burst);
      out_ready <= (rx_hold == 0);
      rx_stall_left <= rx_hold;
    end else if (rx_stall_left > 0) begin
      out_ready <= (rx_stall_left == 1);
      rx_stall_left <= rx_stall_left - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic add_word(input logic [1:0] op, input int ch, input int lvl);
    dmx_in_t w;
    w.operation = op;
    w.channel = ch[CHAN_W-1:0];
    w.level = lvl[7:0];
    words_to_send.push_back(w);
  endtask

  // Mostly ticks, so that frames progress; channels mostly in range.
  task automatic add_random_words(input int count);
    int sel;
    int ch;
    repeat (count) begin
      sel = $urandom_range(0, 99);
      ch = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, N_CH - 1);
      add_word(sel < 75 ? OP_TICK : sel < 88 ? OP_WRITE : sel < 96 ? OP_READ : OP_UNUSED,
               ch, $urandom_range(0, 255));
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_BREAK: len_break = val;
      CFG_MAB: len_mab = val;
      CFG_MBB: len_mbb = val;
      default: len_bit = val[7:0];
    endcase
  endtask

  task automatic apply_setting(input logic [15:0] brk, input logic [15:0] mab,
                               input logic [15:0] mbb, input logic [7:0] bt);
    write_reg(CFG_BREAK, brk);
    write_reg(CFG_MAB, mab);
    write_reg(CFG_MBB, mbb);
    write_reg(CFG_BIT, {8'd0, bt});
    settings_used++;
    @(negedge clk);
  endtask

  // Waits until every queued word is sent and every result has come back.
  task automatic settle();
    while (words_to_send.size() != 0 || in_valid || pending_results.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed words at the reset timing: field extremes and range edges.
    add_word(OP_READ, 0, 0);
    add_word(OP_WRITE, 0, 255);
    add_word(OP_READ, 0, 0);
    add_word(OP_WRITE, N_CH - 1, 0);
    add_word(OP_READ, N_CH - 1, 255);
    add_word(OP_WRITE, N_CH - 1, 'hA5);
    add_word(OP_READ, N_CH - 1, 0);
    add_word(OP_WRITE, N_CH, 255);
    add_word(OP_READ, N_CH, 0);
    add_word(OP_WRITE, 1023, 'h5A);
    add_word(OP_READ, 1023, 255);
    add_word(OP_UNUSED, 0, 255);
    add_word(OP_UNUSED, 1023, 0);
    add_word(OP_READ, 1, 0);
    add_word(OP_WRITE, 1, 'h01);
    add_word(OP_WRITE, 2, 'h80);
    add_word(OP_READ, 2, 0);
    add_word(OP_TICK, 1023, 255);
    add_word(OP_TICK, 0, 0);
    add_word(OP_TICK, 512, 'h55);
    add_random_words(60);
    settle();

    // Shortest lengths end the long break on the next tick.
    apply_setting(16'd1, 16'd1, 16'd1, 8'd1);
    add_random_words(120);
    settle();

    // Zero lengths behave as one.
    apply_setting(16'd0, 16'd0, 16'd0, 8'd0);
    add_random_words(120);
    settle();

    // Longest lengths, then shortened while part way through.
    apply_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
    add_random_words(40);
    settle();
    apply_setting(16'd2, 16'd3, 16'd1, 8'd0);
    add_random_words(120);
    settle();

    repeat (3) begin
      apply_setting(16'($urandom_range(1, 40)), 16'($urandom_range(1, 16)),
                    16'($urandom_range(1, 24)), 8'($urandom_range(0, 3)));
      add_random_words(100);
      settle();
    end

    repeat (10) @(negedge clk);
    $display("Covered %0d ticks, %0d writes, %0d reads and %0d unused codes over %0d settings.",
             n_tick, n_write, n_read, n_unused, settings_used);
    $display("Checked %0d results across %0d complete frames of %0d channels.",
             results_checked, frames_done, N_CH);
    if (fault_count == 0 && pending_results.size() == 0)
      $display("dmx512_frame_transmitter_tb: clean");
    else
      $display("dmx512_frame_transmitter_tb: errors");
    $finish;
  end

endmodule

@@ dmx512_frame_transmitter.f @@
design/dmx_pkg.sv
design/dmx_timing.sv
design/dmx_chan_mem.sv
design/dmx512_frame_transmitter.sv
tb/sv/dmx512_frame_transmitter_tb.sv
